// File: design/ple_pkg.sv
// Shared types, codes and defaults for the positional list editor.
package ple_pkg;

  localparam int DEPTH_DEF = 32;

  localparam int REQ_W   = 2;
  localparam int POS_W   = 6;
  localparam int WORD_W  = 64;
  localparam int STAT_W  = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REPLACE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DUMP    = 2'd3;

  localparam logic [STAT_W-1:0] ST_ENTRY = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_ERROR = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic edit;
    logic dump_start;
    logic dump_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic step_last;
  } stat_t;

endpackage

// File: design/ple_ctrl.sv
// Controller state machine: sequences edits and dump runs.
module ple_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic [ple_pkg::REQ_W-1:0]   req_type,
  output logic                        in_tready,
  input  ple_pkg::stat_t              stat,
  output ple_pkg::cmd_t               cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd.edit       = accept && (req_type != ple_pkg::REQ_DUMP);
    cmd.dump_start = accept && (req_type == ple_pkg::REQ_DUMP);
    cmd.dump_step  = (state_r == S_DUMP) && stat.slot_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.dump_start) state_nxt = S_DUMP;
      end
      S_DUMP: begin
        if (cmd.dump_step && stat.step_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/ple_datapath.sv
// Datapath: entry register array, count, sticky error and output register.
module ple_datapath #(
  parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ple_pkg::cmd_t                cmd,
  output ple_pkg::stat_t               stat,
  input  logic [ple_pkg::REQ_W-1:0]    req_type,
  input  logic [ple_pkg::POS_W-1:0]    position,
  input  logic [ple_pkg::WORD_W-1:0]   word_in,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [ple_pkg::WORD_W-1:0]   out_word,
  output logic [ple_pkg::STAT_W-1:0]   out_status,
  output logic                         out_last
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W + 1) > (ple_pkg::POS_W + 1)) ? (CNT_W + 1)
                                                               : (ple_pkg::POS_W + 1);
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  logic [ple_pkg::WORD_W-1:0] entries_r   [DEPTH];
  logic [ple_pkg::WORD_W-1:0] entries_nxt [DEPTH];
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [CNT_W-1:0]           k_r, k_nxt;
  logic                       error_r, error_nxt;

  logic                       ov_r, ov_nxt;
  logic [ple_pkg::WORD_W-1:0] ow_r, ow_nxt;
  logic [ple_pkg::STAT_W-1:0] os_r, os_nxt;
  logic                       ol_r, ol_nxt;

  logic [CMP_W-1:0] pos_ext, idx, cnt_ext;
  logic             bad, edit_ok, rotate, step_last;

  assign pos_ext = CMP_W'(position);
  assign idx     = pos_ext - CMP_W'(1);
  assign cnt_ext = CMP_W'(cnt_r);

  always_comb begin
    bad = (pos_ext == '0);
    priority case (req_type)
      ple_pkg::REQ_INSERT:
        bad = bad || (pos_ext > cnt_ext + CMP_W'(1)) || (cnt_ext >= DEPTH_C);
      default:
        bad = bad || (pos_ext > cnt_ext);
    endcase
  end

  assign edit_ok   = cmd.edit && !error_r && !bad;
  assign rotate    = cmd.dump_step && !error_r && (cnt_r != '0);
  // A status result ends the run at once; otherwise the last entry does.
  assign step_last = error_r || (cnt_r == '0) || ((k_r + CNT_W'(1)) == cnt_r);

  assign stat.slot_free = !ov_r || out_tready;
  assign stat.step_last = step_last;

  // Each entry looks only at its neighbors, the head entry and the input word.
  for (genvar g = 0; g < DEPTH; g++) begin : g_ent
    logic [ple_pkg::WORD_W-1:0] prev_w, next_w;
    logic [CMP_W-1:0]           ic;
    assign ic = CMP_W'(g);
    if (g > 0) begin : g_prev
      assign prev_w = entries_r[g-1];
    end else begin : g_prev0
      assign prev_w = '0;
    end
    if (g < DEPTH - 1) begin : g_next
      assign next_w = entries_r[g+1];
    end else begin : g_next0
      assign next_w = '0;
    end

    always_comb begin
      entries_nxt[g] = entries_r[g];
      if (edit_ok) begin
        unique case (req_type)
          ple_pkg::REQ_INSERT: begin
            if (ic == idx) entries_nxt[g] = word_in;
            else if (ic > idx && ic <= cnt_ext) entries_nxt[g] = prev_w;
          end
          ple_pkg::REQ_DELETE: begin
            if (ic >= idx && (ic + CMP_W'(1)) < cnt_ext) entries_nxt[g] = next_w;
          end
          ple_pkg::REQ_REPLACE: begin
            if (ic == idx) entries_nxt[g] = word_in;
          end
          default: entries_nxt[g] = entries_r[g];
        endcase
      end else if (rotate) begin
        // Rotate the live entries so the head always holds the next word out.
        if ((ic + CMP_W'(1)) < cnt_ext) entries_nxt[g] = next_w;
        else if ((ic + CMP_W'(1)) == cnt_ext) entries_nxt[g] = entries_r[0];
      end
    end
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    error_nxt = error_r;
    if (cmd.edit && !error_r) begin
      if (bad) begin
        error_nxt = 1'b1;
      end else begin
        unique case (req_type)
          ple_pkg::REQ_INSERT: cnt_nxt = cnt_r + CNT_W'(1);
          ple_pkg::REQ_DELETE: cnt_nxt = cnt_r - CNT_W'(1);
          default:             cnt_nxt = cnt_r;
        endcase
      end
    end
  end

  always_comb begin
    k_nxt = k_r;
    if (cmd.dump_start) k_nxt = '0;
    else if (rotate)    k_nxt = k_r + CNT_W'(1);
  end

  always_comb begin
    ov_nxt = ov_r && !out_tready;
    ow_nxt = ow_r;
    os_nxt = os_r;
    ol_nxt = ol_r;
    if (cmd.dump_step) begin
      ov_nxt = 1'b1;
      ol_nxt = step_last;
      priority if (error_r) begin
        ow_nxt = '0;
        os_nxt = ple_pkg::ST_ERROR;
      end else if (cnt_r == '0) begin
        ow_nxt = '0;
        os_nxt = ple_pkg::ST_EMPTY;
      end else begin
        ow_nxt = entries_r[0];
        os_nxt = ple_pkg::ST_ENTRY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      error_r <= 1'b0;
      ov_r    <= 1'b0;
      k_r     <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      error_r <= error_nxt;
      ov_r    <= ov_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) entries_r[i] <= entries_nxt[i];
    ow_r <= ow_nxt;
    os_r <= os_nxt;
    ol_r <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_word   = ow_r;
  assign out_status = os_r;
  assign out_last   = ol_r;

endmodule

// File: design/positional_list_editor_core.sv
// Top level of the positional list editor: stream ports, controller and datapath.
//
// Holds an ordered list of up to DEPTH 64-bit words addressed by one-based
// position. Insert, delete and replace items never hold off the next item:
// the entry register array shifts all entries in parallel. A dump item emits
// one result per entry, one per cycle while out_tready is high; an empty list
// or a flagged error gives a single status result instead. During a dump the
// entries rotate through the head register into the output register, which
// sets the one-result-per-cycle rate, and no input item is taken until the
// last result of the run has entered the output register. A bad position or
// an insert into a full list sets a sticky error that only reset clears;
// later edits are ignored. No clearing pass is needed after reset.
module positional_list_editor_core #(
  parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // position [5:0], word_in [69:6], zero [71:70]
  input  logic [1:0]  in_tuser,   // req_type [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // word_out [63:0]
  output logic [1:0]  out_tuser,  // status [1:0]
  output logic        out_tlast
);

  ple_pkg::cmd_t  cmd;
  ple_pkg::stat_t stat;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .req_type  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ple_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (in_tuser),
    .position   (in_tdata[5:0]),
    .word_in    (in_tdata[69:6]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_word   (out_tdata),
    .out_status (out_tuser),
    .out_last   (out_tlast)
  );

endmodule

// File: verif/positional_list_editor_core_tb.sv
// Self-checking testbench for the positional list editor: directed table, random edits, errors.
module positional_list_editor_core_tb;
  import ple_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int SCRIPT_LEN = 19;
  localparam int RANDOM_ITEMS = 100;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [STAT_W-1:0] status;
    logic              last;
  } list_result_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
    logic              typed;
    logic [STAT_W-1:0] typed_status;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // Shadow copy of the list, kept in step with accepted items.
  logic [WORD_W-1:0] list_words [DEPTH];
  int                list_len = 0;
  bit                list_broken = 1'b0;
  list_result_t      pending_results [$];

  int mismatch_count = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  script_row_t script [SCRIPT_LEN] = '{
    '{REQ_DUMP,    6'd0, 64'd0,                   1'b1, ST_EMPTY},
    '{REQ_INSERT,  6'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_ENTRY},
    '{REQ_INSERT,  6'd1, 64'h0,                   1'b0, ST_ENTRY},
    '{REQ_INSERT,  6'd3, 64'h5555_5555_5555_5555, 1'b0, ST_ENTRY},
    '{REQ_DUMP,    6'd0, 64'd0,                   1'b0, ST_ENTRY},
    '{REQ_REPLACE, 6'd2, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, ST_ENTRY},
    '{REQ_REPLACE, 6'd3, 64'h8000_0000_0000_0001, 1'b0, ST_ENTRY},
    '{REQ_DUMP,    6'd0, 64'd0,                   1'b0, ST_ENTRY},
    '{REQ_DELETE,  6'd3, 64'd0,                   1'b0, ST_ENTRY},
    '{REQ_DELETE,  6'd1, 64'd0,                   1'b0, ST_ENTRY},
    '{REQ_DUMP,    6'd0, 64'd0,                   1'b0, ST_ENTRY},
    '{REQ_DELETE,  6'd1, 64'd0,                   1'b0, ST_ENTRY},
    '{REQ_DUMP,    6'd0, 64'd0,                   1'b1, ST_EMPTY},
    '{REQ_INSERT,  6'd1, 64'h0123_4567_89AB_CDEF, 1'b0, ST_ENTRY},
    '{REQ_INSERT,  6'd2, 64'hFEDC_BA98_7654_3210, 1'b0, ST_ENTRY},
    '{REQ_INSERT,  6'd2, 64'h1,                   1'b0, ST_ENTRY},
    '{REQ_REPLACE, 6'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_ENTRY},
    '{REQ_DELETE,  6'd2, 64'd0,                   1'b0, ST_ENTRY},
    '{REQ_DUMP,    6'd0, 64'd0,                   1'b0, ST_ENTRY}
  };

  positional_list_editor_core #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    mismatch_count++;
  endtask

  // Applies one accepted request to the shadow list and queues its dump output.
  function automatic void apply_list_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                                             logic [WORD_W-1:0] word);
    int n;
    list_result_t r;
    n = pos;
    if (req == REQ_DUMP) begin
      if (list_broken) begin
        pending_results.push_back('{64'd0, ST_ERROR, 1'b1});
      end else if (list_len == 0) begin
        pending_results.push_back('{64'd0, ST_EMPTY, 1'b1});
      end else begin
        for (int k = 0; k < list_len; k++) begin
          r.word = list_words[k];
          r.status = ST_ENTRY;
          r.last = (k == list_len - 1);
          pending_results.push_back(r);
        end
      end
      return;
    end
    if (list_broken) return;
    case (req)
      REQ_INSERT: begin
        if (n == 0 || n > list_len + 1 || list_len >= DEPTH) begin
          list_broken = 1'b1;
        end else begin
          for (int k = list_len; k >= n; k--) list_words[k] = list_words[k-1];
          list_words[n-1] = word;
          list_len++;
        end
      end
      REQ_DELETE: begin
        if (n == 0 || n > list_len) begin
          list_broken = 1'b1;
        end else begin
          for (int k = n; k < list_len; k++) list_words[k-1] = list_words[k];
          list_len--;
        end
      end
      REQ_REPLACE: begin
        if (n == 0 || n > list_len) list_broken = 1'b1;
        else list_words[n-1] = word;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offers one item, holds it until taken, then updates the shadow list or queues the typed status result.
  task automatic offer_request(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                               input logic [WORD_W-1:0] word, input logic typed,
                               input logic [STAT_W-1:0] typed_status);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, word, pos};
    in_tuser <= req;
    do @(posedge clk); while (!in_tready);
    if (typed) pending_results.push_back('{64'd0, typed_status, 1'b1});
    else apply_list_request(req, pos, word);
  endtask

  task automatic offer_valid_edit();
    int pick;
    logic [REQ_W-1:0] req;
    logic [POS_W-1:0] pos;
    pick = $urandom_range(0, 99);
    if (pick < 40) req = REQ_INSERT;
    else if (pick < 65) req = REQ_DELETE;
    else if (pick < 85) req = REQ_REPLACE;
    else req = REQ_DUMP;
    if (list_len == 0 && req != REQ_DUMP) req = REQ_INSERT;
    if (list_len == DEPTH && req == REQ_INSERT) req = REQ_REPLACE;
    case (req)
      REQ_INSERT: pos = POS_W'($urandom_range(1, list_len + 1));
      REQ_DUMP:   pos = POS_W'($urandom_range(0, 63));
      default:    pos = POS_W'($urandom_range(1, list_len));
    endcase
    offer_request(req, pos, pick_word(), 1'b0, ST_ENTRY);
  endtask

  // Result side: random stalls, one long hold-off on request, field checks.
  initial begin
    int stall;
    list_result_t want;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = idle_on ? $urandom_range(0, 10) : 0;
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", out_tdata, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.word) report_mismatch("word_out", out_tdata, want.word);
        if (out_tuser !== want.status) report_mismatch("status", out_tuser, want.status);
        if (out_tlast !== want.last) report_mismatch("last", out_tlast, want.last);
      end
    end
  end

  initial begin
    #12_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int kind;
    logic [REQ_W-1:0] req;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i])
      offer_request(script[i].req, script[i].pos, script[i].word, script[i].typed,
                    script[i].typed_status);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = ((i / 25) % 3 != 1);
      if (i == RANDOM_ITEMS / 2) begin
        // Freeze the result side during a dump so the input side backs up.
        hold_req = 1'b1;
        offer_request(REQ_DUMP, 6'd0, 64'd0, 1'b0, ST_ENTRY);
      end
      offer_valid_edit();
    end

    // Error tail: set the list up, trigger one kind of error, then check it sticks.
    idle_on = 1'b1;
    kind = $urandom_range(0, 4);
    if (kind == 4) begin
      while (list_len > 0)
        offer_request(REQ_DELETE, POS_W'($urandom_range(1, list_len)), pick_word(), 1'b0,
                      ST_ENTRY);
    end else begin
      while (list_len < DEPTH)
        offer_request(REQ_INSERT, POS_W'($urandom_range(1, list_len + 1)), pick_word(), 1'b0,
                      ST_ENTRY);
    end
    offer_request(REQ_DUMP, 6'd0, 64'd0, 1'b0, ST_ENTRY);
    req = $urandom_range(0, 1) ? REQ_DELETE : REQ_REPLACE;
    case (kind)
      0: offer_request(REQ_INSERT, POS_W'($urandom_range(1, DEPTH + 1)), pick_word(), 1'b0,
                       ST_ENTRY);
      1: offer_request(REQ_INSERT, 6'd0, pick_word(), 1'b0, ST_ENTRY);
      2: offer_request(req, 6'd0, pick_word(), 1'b0, ST_ENTRY);
      3: offer_request(req, POS_W'($urandom_range(DEPTH + 1, 63)), pick_word(), 1'b0,
                       ST_ENTRY);
      default: offer_request(REQ_INSERT, POS_W'($urandom_range(2, 63)), pick_word(), 1'b0,
                             ST_ENTRY);
    endcase
    repeat (10)
      offer_request(REQ_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, 63)), pick_word(),
                    1'b0, ST_ENTRY);
    offer_request(REQ_DUMP, 6'd0, 64'd0, 1'b1, ST_ERROR);
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
